// ===== hw/rtl/bitmap_range_set_clear_macros.svh =====
// Assertion macros used by the bitmap range set/clear back end.
`ifndef BITMAP_RANGE_SET_CLEAR_MACROS_SVH
`define BITMAP_RANGE_SET_CLEAR_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define BMRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition never holds outside reset.
`define BMRS_NEVER(label, cond, msg) \
  `BMRS_ASSERT(label, !(cond), msg)

`endif

// ===== hw/rtl/bmrs_pkg.sv =====
// Shared types and constants of the bitmap range set/clear block.
package bmrs_pkg;

  localparam int unsigned DIV_W = 16;
  localparam int unsigned WIDX_MAX_W = 17;
  localparam int unsigned OFS_MAX_W = 6;
  localparam int unsigned SPAN_MAX_W = 7;

  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_PTR_W;

  localparam logic [2:0] CMD_SET_BIT    = 3'd0;
  localparam logic [2:0] CMD_CLR_BIT    = 3'd1;
  localparam logic [2:0] CMD_FILL_RANGE = 3'd2;
  localparam logic [2:0] CMD_CLR_RANGE  = 3'd3;
  localparam logic [2:0] CMD_TEST_BIT   = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET_BIT,
    OP_CLR_BIT,
    OP_TEST_BIT,
    OP_FILL,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic                  err;
    logic [WIDX_MAX_W-1:0] first;
    logic [WIDX_MAX_W-1:0] last;
    logic [OFS_MAX_W-1:0]  lo;
    logic [SPAN_MAX_W-1:0] hi;
  } job_t;

endpackage

// ===== hw/rtl/bitmap_range_set_clear.sv =====
// Top level of the bitmap range set/clear block: front end, command queue and back end.
// A command passes the front-end register and the command queue to the back end.
// The back end gives the beat of a no-op or error from idle and runs a single-bit command
// through its read and modify states; a range reads and modifies its first and last words
// and writes each word between whole. It takes no new command until it is idle again.
// After reset busy stays high while the memory is cleared word by word.
module bitmap_range_set_clear #(
  parameter int unsigned BITMAP_BITS = 32768,
  parameter int unsigned WORD_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [14:0] bit_position_i,
  input  logic [14:0] range_start_i,
  input  logic [15:0] range_end_i,
  output logic        done_o,
  output logic        bit_value_o,
  output logic        range_error_o
);
  import bmrs_pkg::*;

  logic push, pop, full, empty, clearing;
  job_t push_job, head_job;

  bmrs_front #(
    .BITMAP_BITS(BITMAP_BITS),
    .WORD_BITS  (WORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .hold_i        (clearing),
    .command_i     (command_i),
    .bit_position_i(bit_position_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .full_i        (full),
    .busy_o        (busy),
    .push_o        (push),
    .job_o         (push_job)
  );

  bmrs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .empty_o(empty),
    .full_o (full)
  );

  bmrs_back #(
    .BITMAP_BITS(BITMAP_BITS),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .job_i        (head_job),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .done_o       (done_o),
    .bit_value_o  (bit_value_o),
    .range_error_o(range_error_o)
  );

endmodule

// ===== hw/rtl/bmrs_front.sv =====
// Front end: accepts commands, splits positions into word and offset, classifies.
module bmrs_front #(
  parameter int unsigned BITMAP_BITS = 32768,
  parameter int unsigned WORD_BITS   = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           hold_i,
  input  logic [2:0]     command_i,
  input  logic [14:0]    bit_position_i,
  input  logic [14:0]    range_start_i,
  input  logic [15:0]    range_end_i,
  input  logic           full_i,
  output logic           busy_o,
  output logic           push_o,
  output bmrs_pkg::job_t job_o
);
  import bmrs_pkg::*;

  localparam int unsigned Shift = DIV_W + $clog2(WORD_BITS);
  localparam longint unsigned Recip = ((64'd1 << Shift) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned RecipW = $clog2(Recip + 1);
  localparam int unsigned ProdW = DIV_W + RecipW;

  logic             f1_valid_q, f1_valid_d;
  logic             accept;
  logic             is_range;
  logic [DIV_W-1:0] xa, xb, qa, qb;
  logic [ProdW-1:0] prod_a, prod_b;
  logic [2:0]       cmd_q;
  logic [DIV_W-1:0] xa_q, xb_q, end_q, qa_q, qb_q;
  logic [DIV_W-1:0] ra, rb;
  logic             pos_ok, end_over;
  job_t             job;

  assign busy_o = hold_i || (f1_valid_q && full_i);
  assign accept = start_i && !busy_o;
  assign push_o = f1_valid_q && !full_i;

  assign is_range = (command_i == CMD_FILL_RANGE) || (command_i == CMD_CLR_RANGE);
  assign xa = is_range ? {1'b0, range_start_i} : {1'b0, bit_position_i};
  assign xb = range_end_i - 16'd1;
  assign prod_a = ProdW'(xa) * ProdW'(Recip);
  assign prod_b = ProdW'(xb) * ProdW'(Recip);
  assign qa = DIV_W'(prod_a >> Shift);
  assign qb = DIV_W'(prod_b >> Shift);

  assign f1_valid_d = accept || (f1_valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= f1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      xa_q  <= xa;
      xb_q  <= xb;
      end_q <= range_end_i;
      qa_q  <= qa;
      qb_q  <= qb;
    end
  end

  assign ra = xa_q - DIV_W'(qa_q * DIV_W'(WORD_BITS));
  assign rb = xb_q - DIV_W'(qb_q * DIV_W'(WORD_BITS));
  assign pos_ok = 32'(xa_q) < 32'(BITMAP_BITS);
  assign end_over = 32'(end_q) > 32'(BITMAP_BITS);

  always_comb begin
    job       = '0;
    job.op    = OP_NONE;
    job.first = WIDX_MAX_W'(qa_q);
    job.last  = WIDX_MAX_W'(qb_q);
    job.lo    = ra[OFS_MAX_W-1:0];
    job.hi    = SPAN_MAX_W'(rb) + SPAN_MAX_W'(1);
    unique case (cmd_q)
      CMD_SET_BIT: begin
        job.last = job.first;
        job.err  = !pos_ok;
        job.op   = pos_ok ? OP_SET_BIT : OP_NONE;
      end
      CMD_CLR_BIT: begin
        job.last = job.first;
        job.err  = !pos_ok;
        job.op   = pos_ok ? OP_CLR_BIT : OP_NONE;
      end
      CMD_TEST_BIT: begin
        job.last = job.first;
        job.err  = !pos_ok;
        job.op   = pos_ok ? OP_TEST_BIT : OP_NONE;
      end
      CMD_FILL_RANGE, CMD_CLR_RANGE: begin
        if (end_q > xa_q) begin
          job.err = end_over;
          if (!end_over) begin
            job.op = (cmd_q == CMD_FILL_RANGE) ? OP_FILL : OP_CLEAR;
          end
        end
      end
      default: begin
        job.op = OP_NONE;
      end
    endcase
  end

  assign job_o = job;

endmodule

// ===== hw/rtl/bmrs_fifo.sv =====
// Short command queue between the front end and the back end.
module bmrs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bmrs_pkg::job_t job_i,
  input  logic           pop_i,
  output bmrs_pkg::job_t job_o,
  output logic           empty_o,
  output logic           full_o
);
  import bmrs_pkg::*;

  job_t                   entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign job_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== hw/rtl/bmrs_back.sv =====
// Back end: bitmap memory, clearing pass and the word-by-word command engine.
`include "bitmap_range_set_clear_macros.svh"

module bmrs_back #(
  parameter int unsigned BITMAP_BITS = 32768,
  parameter int unsigned WORD_BITS   = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  bmrs_pkg::job_t job_i,
  output logic           pop_o,
  output logic           clearing_o,
  output logic           done_o,
  output logic           bit_value_o,
  output logic           range_error_o
);
  import bmrs_pkg::*;

  localparam int unsigned NumWords = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WidxW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned OfsW = $clog2(WORD_BITS);
  localparam int unsigned SpanW = $clog2(WORD_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_MOD  = 4'b0100,
    ST_WALK = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  job_t                 exec_q, exec_d;
  logic [WidxW-1:0]     w_q, w_d, w_next;
  logic [WidxW-1:0]     first_w, last_w;
  logic [OfsW-1:0]      lo_idx, lo_eff;
  logic [SpanW-1:0]     hi_eff;
  logic                 at_last;
  logic [WORD_BITS-1:0] mask, bit_mask;
  logic [WORD_BITS-1:0] mem_q [NumWords];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 re, we_cmd, we;
  logic [WORD_BITS-1:0] wdata_cmd, wdata;
  logic [WidxW-1:0]     waddr;
  logic                 clr_busy_q;
  logic [WidxW-1:0]     clr_addr_q;
  logic                 done_q, done_d;
  logic                 bit_q, bit_d;
  logic                 err_q, err_d;

  assign first_w = exec_q.first[WidxW-1:0];
  assign last_w  = exec_q.last[WidxW-1:0];
  assign lo_idx  = exec_q.lo[OfsW-1:0];
  assign at_last = (w_q == last_w);
  assign lo_eff  = (w_q == first_w) ? lo_idx : '0;
  assign hi_eff  = at_last ? exec_q.hi[SpanW-1:0] : SpanW'(WORD_BITS);
  assign w_next  = w_q + 1'b1;
  assign bit_mask = WORD_BITS'(1) << lo_idx;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (i >= int'(lo_eff)) && (i < int'(hi_eff));
    end
  end

  always_comb begin
    state_d   = state_q;
    exec_d    = exec_q;
    w_d       = w_q;
    pop_o     = 1'b0;
    re        = 1'b0;
    we_cmd    = 1'b0;
    wdata_cmd = '0;
    done_d    = 1'b0;
    bit_d     = bit_q;
    err_d     = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i && !clr_busy_q) begin
          pop_o  = 1'b1;
          exec_d = job_i;
          w_d    = job_i.first[WidxW-1:0];
          if (job_i.op == OP_NONE) begin
            done_d = 1'b1;
            bit_d  = 1'b0;
            err_d  = job_i.err;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        re      = 1'b1;
        state_d = ST_MOD;
      end
      ST_MOD, ST_WALK: begin
        if (state_q == ST_WALK) begin
          we_cmd    = 1'b1;
          wdata_cmd = (exec_q.op == OP_FILL) ? '1 : '0;
        end else begin
          unique case (exec_q.op)
            OP_SET_BIT: begin
              we_cmd    = 1'b1;
              wdata_cmd = rdata_q | bit_mask;
            end
            OP_CLR_BIT: begin
              we_cmd    = 1'b1;
              wdata_cmd = rdata_q & ~bit_mask;
            end
            OP_FILL: begin
              we_cmd    = 1'b1;
              wdata_cmd = rdata_q | mask;
            end
            OP_CLEAR: begin
              we_cmd    = 1'b1;
              wdata_cmd = rdata_q & ~mask;
            end
            default: begin
              we_cmd = 1'b0;
            end
          endcase
        end
        if (at_last) begin
          done_d  = 1'b1;
          err_d   = 1'b0;
          bit_d   = (state_q == ST_MOD) && (exec_q.op == OP_TEST_BIT) && rdata_q[lo_idx];
          state_d = ST_IDLE;
        end else begin
          w_d     = w_next;
          state_d = (w_next == last_w) ? ST_RD : ST_WALK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign we    = clr_busy_q || we_cmd;
  assign waddr = clr_busy_q ? clr_addr_q : w_q;
  assign wdata = clr_busy_q ? '0 : wdata_cmd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem_q[w_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      done_q     <= 1'b0;
      bit_q      <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      bit_q   <= bit_d;
      err_q   <= err_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == WidxW'(NumWords - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    exec_q <= exec_d;
    w_q    <= w_d;
  end

  assign clearing_o    = clr_busy_q;
  assign done_o        = done_q;
  assign bit_value_o   = bit_q;
  assign range_error_o = err_q;

  `BMRS_NEVER(a_no_work_in_clear, clr_busy_q && (state_q != ST_IDLE), "Command work overlapped the clearing pass.")
  `BMRS_ASSERT(a_rd_has_op, (state_q == ST_RD) |-> (exec_q.op != OP_NONE), "Memory read issued for a command without work.")
  `BMRS_ASSERT(a_walk_not_last, (state_q == ST_WALK) |-> (w_q != last_w), "Whole-word write reached the last word of a range.")
  `BMRS_ASSERT(a_value_from_test, (done_q && bit_q) |-> (exec_q.op == OP_TEST_BIT), "Bit value reported for a command other than test.")

endmodule
